/* sv/kmer_bloom_filter_macros.svh */
// kmer_bloom_filter_macros.svh: assertion macros for the k-mer bloom filter
// depends on nothing; included inside module bodies
`ifndef KMER_BLOOM_FILTER_MACROS_SVH
`define KMER_BLOOM_FILTER_MACROS_SVH
// implication checked on every clock, disabled while in reset
`define KBF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KBF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* sv/kbf_pkg.sv */
// kbf_pkg: types and constants of the k-mer bloom filter
// depends on nothing
package kbf_pkg;
	localparam int NUM_HASHES = 7;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_FILTER = 1'b1;
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_MOD   = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	// one bit per hash for a base: 0 for listed letters
	function automatic logic [NUM_HASHES-1:0] base_bits(input logic [7:0] ch);
		logic a, c, g, t;
		a = (ch == CH_A);
		c = (ch == CH_C);
		g = (ch == CH_G);
		t = (ch == CH_T);
		return {~t, ~g, ~c, ~a, ~(a | t), ~(a | g), ~(a | c)};
	endfunction
endpackage

/* sv/kmer_bloom_filter.sv */
// Bloom filter over DNA k-mers, one base per transfer on s_axis. Seven rolling
// 64-bit window hashes index a 2^ADDR_BITS x 1 bit store, reset by a clearing
// pass over its 2^(ADDR_BITS-6) 64-bit rows during which no base is taken.
// A base whose window is not yet full is taken with no further work, and the
// next base can follow at once. Once the window is full, each of the seven
// hashes is reduced modulo filter_bits by a bit-serial remainder unit and
// probed on the store in the steps read, wait, write; an insert sets the bit,
// a query only reads it. No base is taken until all seven are done. A query
// then loads its result register, waiting while an earlier result still sits
// there, and gives one transfer on m_axis; the next base is taken while that
// result waits. An insert gives none.
module kmer_bloom_filter #(
	parameter int ADDR_BITS = 20,
	parameter int MAX_WINDOW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // base
	input  logic [1:0]  s_axis_tuser,  // mode[0], start_of_read[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // present, zeros
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_wdata
);
	import kbf_pkg::*;
	`include "kmer_bloom_filter_macros.svh"

	localparam int ROWB = (ADDR_BITS > 6) ? ADDR_BITS - 6 : 1;
	localparam int ROWS = 1 << ROWB;
	localparam int FW = ADDR_BITS + 1;
	localparam int FCW = $clog2(MAX_WINDOW + 1);

	state_t state_q;
	logic [6:0] win_q;
	logic [20:0] fbits_q;
	logic [63:0] hash_q [NUM_HASHES];
	logic [FCW-1:0] fill_q;
	logic mode_q, all_q, present_q, ovalid_q;
	logic [2:0] hsel_q;
	logic [6:0] cnt_q;
	logic [FW:0] rem_q;
	logic [63:0] div_q;
	logic [ROWB-1:0] clr_q;
	logic [ROWB-1:0] raddr_q;
	logic [5:0] bsel_q;
	logic [63:0] mem [ROWS];
	logic [63:0] rdata_q;

	// effective window and modulus
	logic [6:0] q_eff;
	logic [FW-1:0] mod_eff;
	logic [63:0] mask;
	always_comb begin
		q_eff = (win_q == 7'd0) ? 7'd1 : win_q;
		if (q_eff > 7'(MAX_WINDOW)) q_eff = 7'(MAX_WINDOW);
		if (fbits_q == 21'd0) mod_eff = FW'(1);
		else if ({11'd0, fbits_q} > (32'd1 << ADDR_BITS)) mod_eff = FW'(1) << ADDR_BITS;
		else mod_eff = FW'(fbits_q);
		mask = (q_eff >= 7'd64) ? '1 : ((64'd1 << q_eff[5:0]) - 64'd1);
	end

	logic s_fire;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, present_q};

	// new hashes and fill after shifting this base in
	logic [NUM_HASHES-1:0] bb;
	logic [63:0] nh [NUM_HASHES];
	logic [FCW-1:0] nfill;
	always_comb begin
		bb = base_bits(s_axis_tdata);
		for (int i = 0; i < NUM_HASHES; i++) begin
			nh[i] = s_axis_tuser[1] ? 64'd0 : hash_q[i];
			nh[i] = ((nh[i] >> 1) | (64'(bb[i]) << (q_eff - 7'd1))) & mask;
		end
		nfill = s_axis_tuser[1] ? '0 : fill_q;
		if (nfill < FCW'(MAX_WINDOW)) nfill = nfill + FCW'(1);
	end

	// restoring remainder step
	logic [FW:0] rsh;
	assign rsh = {rem_q[FW-1:0], div_q[63]};
	logic [ADDR_BITS-1:0] idx;
	assign idx = rem_q[ADDR_BITS-1:0];

	// bit store, one 64-bit row per access
	logic mem_we;
	logic [ROWB-1:0] mem_wa;
	logic [63:0] mem_wd;
	always_comb begin
		mem_we = (state_q == ST_CLEAR) || ((state_q == ST_WR) && (mode_q == MODE_INSERT));
		mem_wa = (state_q == ST_CLEAR) ? clr_q : raddr_q;
		mem_wd = (state_q == ST_CLEAR) ? 64'd0 : (rdata_q | (64'd1 << bsel_q));
	end
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[raddr_q];
	end

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			win_q <= 7'd32;
			fbits_q <= 21'd1048576;
			fill_q <= '0;
			for (int i = 0; i < NUM_HASHES; i++) hash_q[i] <= '0;
			ovalid_q <= 1'b0;
			present_q <= 1'b0;
			mode_q <= 1'b0;
			all_q <= 1'b0;
			rem_q <= '0;
			div_q <= '0;
			raddr_q <= '0;
			bsel_q <= '0;
			clr_q <= '0;
			hsel_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW) win_q <= cfg_wdata[6:0];
				else fbits_q <= cfg_wdata;
			end
			// result register: loads at the end of a query, clears on its transfer
			if (state_q == ST_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROWB'(1);
					if (clr_q == ROWB'(ROWS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_fire) begin
						for (int i = 0; i < NUM_HASHES; i++) hash_q[i] <= nh[i];
						fill_q <= nfill;
						mode_q <= s_axis_tuser[0];
						all_q <= 1'b1;
						hsel_q <= '0;
						if (7'(nfill) >= q_eff) begin
							state_q <= ST_MOD;
							cnt_q <= '0;
							rem_q <= '0;
							div_q <= nh[0];
						end
					end
				end
				ST_MOD: begin
					rem_q <= (rsh >= {1'b0, mod_eff}) ? rsh - {1'b0, mod_eff} : rsh;
					div_q <= div_q << 1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= ST_RD;
				end
				ST_RD: begin
					raddr_q <= ROWB'(idx >> 6);
					bsel_q <= idx[5:0];
					state_q <= ST_WAIT;
				end
				ST_WAIT: state_q <= ST_WR;
				ST_WR: begin
					// read data valid now; write happens only for insert
					if (mode_q == MODE_QUERY && !rdata_q[bsel_q]) all_q <= 1'b0;
					if (hsel_q == 3'(NUM_HASHES - 1)) begin
						state_q <= (mode_q == MODE_QUERY) ? ST_OUT : ST_IDLE;
					end else begin
						hsel_q <= hsel_q + 3'd1;
						cnt_q <= '0;
						rem_q <= '0;
						div_q <= hash_q[hsel_q + 3'd1];
						state_q <= ST_MOD;
					end
				end
				ST_OUT: begin
					// wait while an earlier result still sits in the register
					if (!ovalid_q || m_axis_tready) begin
						present_q <= all_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`KBF_ASSERT_IMP(a_no_take_busy, state_q != ST_IDLE, !s_axis_tready, "input taken while busy")
	`KBF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`KBF_ASSERT_IMP(a_rem_range, state_q == ST_RD, rem_q < {1'b0, mod_eff}, "remainder out of range")
	`KBF_ASSERT_IMP(a_out_from_end, $rose(ovalid_q), $past(state_q) == ST_OUT, "stray result")
endmodule

/* test/testbench.sv */
// testbench for kmer_bloom_filter: streams reads of bases with random gaps and
// checks every query result against a bloom predictor; depends on kbf_pkg and kmer_bloom_filter
`timescale 1ns / 1ps
module testbench;
	import kbf_pkg::*;

	localparam int STORE_BITS = 1 << 20;
	localparam int DRAIN_CYCLES = 800;
	localparam longint CYCLE_LIMIT = 6000000;

	// predicts the present flag of each query from its own copy of the filter
	class bloom_predictor;
		bit store [STORE_BITS];
		logic [63:0] windows [NUM_HASHES];
		int unsigned fill;
		logic [6:0] win_reg;
		logic [20:0] filt_reg;
		bit present_q [$];
		int unsigned errors;

		function new();
			win_reg = 7'd32;
			filt_reg = 21'd1048576;
			fill = 0;
			errors = 0;
			foreach (windows[i]) windows[i] = '0;
		endfunction

		function void write_reg(logic idx, logic [20:0] v);
			if (idx == REG_WINDOW)
				win_reg = v[6:0];
			else
				filt_reg = v;
		endfunction

		// one hash bit per base: zero only for the letters of that hash
		function bit letter_bit(int h, logic [7:0] ch);
			case (h)
				0: return !(ch == CH_A || ch == CH_C);
				1: return !(ch == CH_A || ch == CH_G);
				2: return !(ch == CH_A || ch == CH_T);
				3: return ch != CH_A;
				4: return ch != CH_C;
				5: return ch != CH_G;
				default: return ch != CH_T;
			endcase
		endfunction

		function void take_base(logic mode, logic [7:0] ch, logic sor);
			int unsigned q;
			logic [63:0] mask, modulus, h;
			bit all_set;
			q = (win_reg == 0) ? 1 : (win_reg > 64) ? 64 : win_reg;
			mask = (q == 64) ? '1 : ((64'd1 << q) - 1);
			modulus = (filt_reg == 0) ? 1 : (filt_reg > STORE_BITS) ? STORE_BITS : filt_reg;
			all_set = 1;
			if (sor) begin
				foreach (windows[i]) windows[i] = '0;
				fill = 0;
			end
			for (int i = 0; i < NUM_HASHES; i++) begin
				h = (windows[i] >> 1) | (64'(letter_bit(i, ch)) << (q - 1));
				windows[i] = h & mask;
			end
			if (fill < 64)
				fill++;
			if (fill < q)
				return;
			for (int i = 0; i < NUM_HASHES; i++) begin
				h = windows[i] % modulus;
				if (mode == MODE_INSERT)
					store[h[19:0]] = 1;
				else if (!store[h[19:0]])
					all_set = 0;
			end
			if (mode == MODE_QUERY)
				present_q = {present_q, all_set};
		endfunction

		function void check_present(bit got);
			bit want;
			if (present_q.size() == 0) begin
				$display("%0t: unexpected result present=%0b", $time, got);
				errors++;
				return;
			end
			want = present_q.pop_front();
			if (want != got) begin
				$display("%0t: present mismatch, expected %0b actual %0b", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [7:0] m_axis_tdata;
	logic cfg_we = 0;
	logic cfg_index = REG_WINDOW;
	logic [20:0] cfg_wdata = '0;

	bloom_predictor bloom = new();
	longint cycles = 0;
	logic [7:0] read_buf [$];

	kmer_bloom_filter u_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// random gap length: mostly short, sometimes long
	function int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// result side: random stalls, check each transfer
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			bloom.check_present(m_axis_tdata[0]);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 0;
		end else begin
			stall_left <= gap_len();
			m_axis_tready <= 1;
		end
	end

	task automatic send_base(logic mode, logic [7:0] ch, logic sor);
		int unsigned g;
		s_axis_tvalid <= 1;
		s_axis_tdata <= ch;
		s_axis_tuser <= {sor, mode};
		do @(posedge clk); while (!s_axis_tready);
		bloom.take_base(mode, ch, sor);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// write a register once the block has gone quiet
	task automatic write_reg(logic idx, logic [20:0] v);
		s_axis_tvalid <= 0;
		while (bloom.present_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		bloom.write_reg(idx, v);
	endtask

	function logic [7:0] pick_base();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(0, 255)) | 8'h80;
			2, 3, 4, 5: return CH_A;
			6, 7, 8, 9: return CH_C;
			10, 11, 12, 13, 14: return CH_G;
			default: return CH_T;
		endcase
	endfunction

	// one read: fresh bases into read_buf, or a replay of the last one
	task automatic run_read(logic mode, int unsigned len, bit replay, bit keep_going);
		if (!replay) begin
			read_buf.delete();
			repeat (len) read_buf = {read_buf, pick_base()};
		end
		foreach (read_buf[i])
			send_base(mode, read_buf[i], (i == 0) && !keep_going);
	endtask

	initial begin
		int unsigned wl, len;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: letters and odd bytes at reset settings, then extremes
		run_read(MODE_INSERT, 33, 0, 0);
		run_read(MODE_QUERY, 0, 1, 0);
		write_reg(REG_WINDOW, 21'd0);
		write_reg(REG_FILTER, 21'd0);
		send_base(MODE_QUERY, 8'hFF, 1);
		send_base(MODE_INSERT, 8'h00, 0);
		send_base(MODE_QUERY, 8'h61, 0);
		write_reg(REG_FILTER, 21'h1FFFFF);
		write_reg(REG_WINDOW, 21'd127);
		run_read(MODE_INSERT, 66, 0, 0);
		run_read(MODE_QUERY, 0, 1, 0);
		write_reg(REG_WINDOW, 21'd3);
		send_base(MODE_QUERY, CH_T, 0);

		// random phases: each picks a setting, then insert and query reads
		for (int ph = 0; ph < 16; ph++) begin
			wl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			write_reg(REG_WINDOW, 21'(wl));
			case ($urandom_range(0, 4))
				0: write_reg(REG_FILTER, 21'($urandom_range(0, 64)));
				1: write_reg(REG_FILTER, 21'($urandom_range(0, 2097151)));
				2: write_reg(REG_FILTER, 21'd1048576);
				default: write_reg(REG_FILTER, 21'($urandom_range(100, 5000)));
			endcase
			if (wl == 0) wl = 1;
			if (wl > 64) wl = 64;
			// carry on the previous read across the setting change now and then
			if ($urandom_range(0, 3) == 0)
				run_read(1'($urandom_range(0, 1)), $urandom_range(1, 8), 0, 1);
			for (int r = 0; r < 3; r++) begin
				len = wl + $urandom_range(0, 8);
				run_read(MODE_INSERT, len, 0, 0);
				run_read(MODE_QUERY, len, $urandom_range(0, 2) != 0, 0);
				if ($urandom_range(0, 3) == 0)
					run_read(1'($urandom_range(0, 1)), $urandom_range(1, len), 0, 0);
			end
		end

		s_axis_tvalid <= 0;
		while (bloom.present_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bloom.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
+incdir+sv
sv/kbf_pkg.sv
sv/kmer_bloom_filter.sv
test/testbench.sv
